@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL; they compile away under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ICMP4ER_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
`define ICMP4ER_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ICMP4ER_ASSERT(lbl, clk, rstn, prop)
`define ICMP4ER_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

@@ rtl/icmp4er_pkg.sv @@
package icmp4er_pkg;

    localparam int MAX_PACKET_DEF = 65535;

    localparam logic [7:0] PROTO_ICMP      = 8'd1;
    localparam logic [7:0] TYPE_ECHO_REPLY = 8'd0;
    localparam logic [7:0] TYPE_UNREACH    = 8'd3;
    localparam logic [7:0] TYPE_ECHO       = 8'd8;

    localparam logic [1:0] VERDICT_DROP    = 2'd0;
    localparam logic [1:0] VERDICT_REPLY   = 2'd1;
    localparam logic [1:0] VERDICT_UNREACH = 2'd2;
    localparam logic [1:0] VERDICT_OTHER   = 2'd3;

    localparam int ICMP_HDR = 8;
    localparam int IP_HDR   = 20;
    localparam int ERR_MIN  = 2 * ICMP_HDR + IP_HDR;

    // outer IP header byte offsets
    localparam int OFF_PROTO = 9;
    localparam int OFF_SRC   = 12;

    // offsets relative to the start of the ICMP header
    localparam int OFF_KIND     = 0;
    localparam int OFF_IDENT    = 4;
    localparam int OFF_SEQ      = 6;
    localparam int OFF_IN_PROTO = ICMP_HDR + 9;
    localparam int OFF_IN_DEST  = ICMP_HDR + 16;
    localparam int OFF_IN_KIND  = ICMP_HDR + IP_HDR;
    localparam int OFF_IN_IDENT = ICMP_HDR + IP_HDR + 4;
    localparam int OFF_IN_SEQ   = ICMP_HDR + IP_HDR + 6;

    typedef struct packed {
        logic [7:0]  outer_proto;
        logic [31:0] source_addr;
        logic [7:0]  icmp_kind;
        logic [15:0] reply_ident;
        logic [15:0] reply_seq;
        logic [7:0]  inner_proto;
        logic [31:0] inner_dest;
        logic [7:0]  inner_kind;
        logic [15:0] inner_ident;
        logic [15:0] inner_seq;
    } t_fields;

    typedef struct packed {
        t_fields f;
        logic    len_icmp_ok;
        logic    len_err_ok;
    } t_pkt;

    typedef struct packed {
        logic valid;
        logic ready;
    } t_out_status;

endpackage

@@ rtl/icmp4er_parse.sv @@
`include "assert_macros.svh"

module icmp4er_parse #(
    parameter int MAX_PACKET = icmp4er_pkg::MAX_PACKET_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [7:0]               i_byte,
    input  logic                     i_last,
    input  icmp4er_pkg::t_out_status i_out,
    output logic                     o_fire,
    output icmp4er_pkg::t_pkt        o_pkt
);

    localparam int CW = $clog2(MAX_PACKET + 1);
    localparam logic [CW-1:0] MaxCount = CW'(MAX_PACKET);

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_last;
    logic [CW-1:0]        r_count;
    logic [5:0]           r_hl;
    icmp4er_pkg::t_fields r_f;

    logic [CW-1:0]        n_count;
    logic [5:0]           n_hl;
    icmp4er_pkg::t_fields n_f;
    logic [CW-1:0]        hl_ext;
    logic [CW-1:0]        rel;
    logic                 take;
    logic                 in_icmp;
    logic                 advance;

    // Hold a last byte while the result slot is occupied and not taken this cycle.
    assign advance = r_in_valid && !(r_in_last && i_out.valid && !i_out.ready);
    assign o_ready = !r_in_valid || advance;
    assign o_fire  = advance && r_in_last;

    always_comb begin
        take    = r_count < MaxCount;
        n_hl    = (r_count == '0) ? {r_in_byte[3:0], 2'b00} : r_hl;
        hl_ext  = CW'(n_hl);
        in_icmp = r_count >= hl_ext;
        rel     = r_count - hl_ext;
        n_count = take ? r_count + CW'(1) : r_count;
        n_f     = r_f;
        if (take) begin
            if (r_count == CW'(icmp4er_pkg::OFF_PROTO)) begin
                n_f.outer_proto = r_in_byte;
            end
            for (int k = 0; k < 4; k++) begin
                if (r_count == CW'(icmp4er_pkg::OFF_SRC + k)) begin
                    n_f.source_addr[8*(3-k) +: 8] = r_in_byte;
                end
                if (in_icmp && rel == CW'(icmp4er_pkg::OFF_IN_DEST + k)) begin
                    n_f.inner_dest[8*(3-k) +: 8] = r_in_byte;
                end
            end
            if (in_icmp) begin
                for (int k = 0; k < 2; k++) begin
                    if (rel == CW'(icmp4er_pkg::OFF_IDENT + k)) begin
                        n_f.reply_ident[8*(1-k) +: 8] = r_in_byte;
                    end
                    if (rel == CW'(icmp4er_pkg::OFF_SEQ + k)) begin
                        n_f.reply_seq[8*(1-k) +: 8] = r_in_byte;
                    end
                    if (rel == CW'(icmp4er_pkg::OFF_IN_IDENT + k)) begin
                        n_f.inner_ident[8*(1-k) +: 8] = r_in_byte;
                    end
                    if (rel == CW'(icmp4er_pkg::OFF_IN_SEQ + k)) begin
                        n_f.inner_seq[8*(1-k) +: 8] = r_in_byte;
                    end
                end
                if (rel == CW'(icmp4er_pkg::OFF_KIND)) begin
                    n_f.icmp_kind = r_in_byte;
                end
                if (rel == CW'(icmp4er_pkg::OFF_IN_PROTO)) begin
                    n_f.inner_proto = r_in_byte;
                end
                if (rel == CW'(icmp4er_pkg::OFF_IN_KIND)) begin
                    n_f.inner_kind = r_in_byte;
                end
            end
        end
        o_pkt.f           = n_f;
        o_pkt.len_icmp_ok = n_count >= hl_ext + CW'(icmp4er_pkg::ICMP_HDR);
        o_pkt.len_err_ok  = n_count >= CW'(icmp4er_pkg::ERR_MIN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_count    <= '0;
            r_hl       <= '0;
            r_f        <= '0;
        end else begin
            if (i_valid && o_ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                if (r_in_last) begin
                    r_count <= '0;
                    r_hl    <= '0;
                    r_f     <= '0;
                end else begin
                    r_count <= n_count;
                    r_hl    <= n_hl;
                    r_f     <= n_f;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_byte;
            r_in_last <= i_last;
        end
    end

    `ICMP4ER_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= MaxCount)
    `ICMP4ER_ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n, o_fire, r_count == '0 && r_hl == '0)
    `ICMP4ER_ASSERT(a_stall_only_last, i_clk, i_rst_n, o_ready || (r_in_valid && r_in_last))

endmodule

@@ rtl/icmp4er_decide.sv @@
`include "assert_macros.svh"

module icmp4er_decide (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [15:0]              i_cfg_wdata,
    input  logic                     i_fire,
    input  icmp4er_pkg::t_pkt        i_pkt,
    output icmp4er_pkg::t_out_status o_status,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [1:0]               o_verdict,
    output logic [31:0]              o_target_addr,
    output logic [15:0]              o_echo_seq
);

    logic [15:0] r_echo_ident;
    logic        r_valid;
    logic [1:0]  r_verdict;
    logic [31:0] r_addr;
    logic [15:0] r_seq;

    logic [1:0]  n_verdict;
    logic [31:0] n_addr;
    logic [15:0] n_seq;

    always_comb begin
        n_verdict = icmp4er_pkg::VERDICT_DROP;
        n_addr    = '0;
        n_seq     = '0;
        if (i_pkt.f.outer_proto == icmp4er_pkg::PROTO_ICMP && i_pkt.len_icmp_ok) begin
            if (i_pkt.f.icmp_kind == icmp4er_pkg::TYPE_ECHO_REPLY) begin
                if (i_pkt.f.reply_ident == r_echo_ident) begin
                    n_verdict = icmp4er_pkg::VERDICT_REPLY;
                    n_addr    = i_pkt.f.source_addr;
                    n_seq     = i_pkt.f.reply_seq;
                end
            end else if (i_pkt.len_err_ok
                         && i_pkt.f.inner_proto == icmp4er_pkg::PROTO_ICMP
                         && i_pkt.f.inner_kind == icmp4er_pkg::TYPE_ECHO
                         && i_pkt.f.inner_ident == r_echo_ident) begin
                n_verdict = (i_pkt.f.icmp_kind == icmp4er_pkg::TYPE_UNREACH)
                            ? icmp4er_pkg::VERDICT_UNREACH : icmp4er_pkg::VERDICT_OTHER;
                n_addr    = i_pkt.f.inner_dest;
                n_seq     = i_pkt.f.inner_seq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo_ident <= '0;
            r_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_echo_ident <= i_cfg_wdata;
            end
            if (i_fire) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_verdict <= n_verdict;
            r_addr    <= n_addr;
            r_seq     <= n_seq;
        end
    end

    assign o_status.valid = r_valid;
    assign o_status.ready = i_ready;
    assign o_valid        = r_valid;
    assign o_verdict      = r_verdict;
    assign o_target_addr  = r_addr;
    assign o_echo_seq     = r_seq;

    `ICMP4ER_ASSERT(a_no_overwrite, i_clk, i_rst_n, !(i_fire && r_valid && !i_ready))
    `ICMP4ER_ASSERT(a_drop_is_zero, i_clk, i_rst_n, !(r_valid && r_verdict == icmp4er_pkg::VERDICT_DROP) || (r_addr == '0 && r_seq == '0))

endmodule

@@ rtl/icmp4_echo_reply_classifier.sv @@
// Channel   | Direction | Payload
// ----------+-----------+-------------------------------------------------
// s_axis    | in        | tdata[7:0] packet byte, tlast final byte
// m_axis    | out       | tdata[31:0] target_addr, [47:32] echo_seq;
//           |           | tuser[1:0] verdict
// cfg       | in        | wdata[15:0] echo identifier, taken when we is high
//
// One byte per cycle sustained; a byte passes an input register, then the field
// capture and verdict logic, and a verdict lands in the result register as the
// last byte leaves the input register. Synchronous active-low reset clears all
// packet state and the identifier. A last byte waits in the input register while
// the result register holds a verdict that is not taken in that same cycle;
// other bytes never stall.
module icmp4_echo_reply_classifier #(
    parameter int MAX_PACKET = icmp4er_pkg::MAX_PACKET_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side: one request is one packet byte
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // data_byte
    input  logic        i_s_axis_tlast,   // last_byte
    // master side: one request is one verdict per packet
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // target_addr[31:0], echo_seq[47:32]
    output logic [1:0]  o_m_axis_tuser,   // verdict[1:0]
    // configuration: identifier carried by our echo requests
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    logic                     fire;
    icmp4er_pkg::t_pkt        pkt;
    icmp4er_pkg::t_out_status out_status;
    logic [31:0]              target_addr;
    logic [15:0]              echo_seq;

    // Capture header fields byte by byte; flag the packet end.
    icmp4er_parse #(
        .MAX_PACKET (MAX_PACKET)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_byte  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .i_out   (out_status),
        .o_fire  (fire),
        .o_pkt   (pkt)
    );

    // Classify on the last byte and hold the verdict until taken.
    icmp4er_decide u_decide (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_fire        (fire),
        .i_pkt         (pkt),
        .o_status      (out_status),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_verdict     (o_m_axis_tuser),
        .o_target_addr (target_addr),
        .o_echo_seq    (echo_seq)
    );

    assign o_m_axis_tdata = {echo_seq, target_addr};

endmodule

@@ test/echo_verdict_checker.sv @@
`timescale 1ns / 1ps

// Watches the byte stream, the verdict stream and identifier writes, keeps its
// own copy of the per-packet capture state and checks each verdict in order.
module echo_verdict_checker #(
    parameter int MAX_PACKET = icmp4er_pkg::MAX_PACKET_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [47:0] i_m_tdata,
    input  logic [1:0]  i_m_tuser,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_verdicts,
    output int          o_hits
);

    typedef struct packed {
        logic [1:0]  verdict;
        logic [31:0] target;
        logic [15:0] seq;
    } t_verdict;

    t_verdict    verdict_q[$];
    t_verdict    want;
    t_verdict    got;
    int          fails;
    int          checked;
    int          hits;

    logic [15:0] ident_cfg;
    int          pkt_len;
    logic [5:0]  hdr_bytes;
    logic [7:0]  ip_proto;
    logic [31:0] ip_src;
    logic [7:0]  msg_type;
    logic [15:0] msg_ident;
    logic [15:0] msg_seq;
    logic [7:0]  emb_proto;
    logic [31:0] emb_dst;
    logic [7:0]  emb_type;
    logic [15:0] emb_ident;
    logic [15:0] emb_seq;

    // OR byte b into a big-endian field of nbytes starting at offset start
    function automatic logic [31:0] be_put(logic [31:0] field, int pos, int start,
                                           int nbytes, logic [7:0] b);
        if (pos >= start && pos < start + nbytes)
            field |= 32'(b) << (8 * (start + nbytes - 1 - pos));
        return field;
    endfunction

    task automatic clear_capture();
        pkt_len   = 0;
        hdr_bytes = '0;
        ip_proto  = '0;
        ip_src    = '0;
        msg_type  = '0;
        msg_ident = '0;
        msg_seq   = '0;
        emb_proto = '0;
        emb_dst   = '0;
        emb_type  = '0;
        emb_ident = '0;
        emb_seq   = '0;
    endtask

    task automatic capture_byte(logic [7:0] b);
        int r;
        // past the saturation point bytes are dropped as if never received
        if (pkt_len >= MAX_PACKET)
            return;
        if (pkt_len == 0)
            hdr_bytes = {b[3:0], 2'b00};
        ip_proto = 8'(be_put(32'(ip_proto), pkt_len, icmp4er_pkg::OFF_PROTO, 1, b));
        ip_src   = be_put(ip_src, pkt_len, icmp4er_pkg::OFF_SRC, 4, b);
        if (pkt_len >= int'(hdr_bytes)) begin
            r = pkt_len - int'(hdr_bytes);
            msg_type  = 8'(be_put(32'(msg_type), r, icmp4er_pkg::OFF_KIND, 1, b));
            msg_ident = 16'(be_put(32'(msg_ident), r, icmp4er_pkg::OFF_IDENT, 2, b));
            msg_seq   = 16'(be_put(32'(msg_seq), r, icmp4er_pkg::OFF_SEQ, 2, b));
            emb_proto = 8'(be_put(32'(emb_proto), r, icmp4er_pkg::OFF_IN_PROTO, 1, b));
            emb_dst   = be_put(emb_dst, r, icmp4er_pkg::OFF_IN_DEST, 4, b);
            emb_type  = 8'(be_put(32'(emb_type), r, icmp4er_pkg::OFF_IN_KIND, 1, b));
            emb_ident = 16'(be_put(32'(emb_ident), r, icmp4er_pkg::OFF_IN_IDENT, 2, b));
            emb_seq   = 16'(be_put(32'(emb_seq), r, icmp4er_pkg::OFF_IN_SEQ, 2, b));
        end
        pkt_len++;
    endtask

    function automatic t_verdict judge_packet();
        t_verdict v;
        v = '0;
        v.verdict = icmp4er_pkg::VERDICT_DROP;
        if (ip_proto == icmp4er_pkg::PROTO_ICMP &&
            pkt_len >= int'(hdr_bytes) + icmp4er_pkg::ICMP_HDR) begin
            if (msg_type == icmp4er_pkg::TYPE_ECHO_REPLY) begin
                if (msg_ident == ident_cfg) begin
                    v.verdict = icmp4er_pkg::VERDICT_REPLY;
                    v.target  = ip_src;
                    v.seq     = msg_seq;
                end
            end else if (pkt_len >= icmp4er_pkg::ERR_MIN &&
                         emb_proto == icmp4er_pkg::PROTO_ICMP &&
                         emb_type == icmp4er_pkg::TYPE_ECHO && emb_ident == ident_cfg) begin
                v.verdict = (msg_type == icmp4er_pkg::TYPE_UNREACH)
                            ? icmp4er_pkg::VERDICT_UNREACH : icmp4er_pkg::VERDICT_OTHER;
                v.target  = emb_dst;
                v.seq     = emb_seq;
            end
        end
        return v;
    endfunction

    task automatic note_failure();
        fails++;
    endtask

    initial begin
        fails     = 0;
        checked   = 0;
        hits      = 0;
        ident_cfg = '0;
        clear_capture();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ident_cfg = '0;
            clear_capture();
            verdict_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.verdict = i_m_tuser;
                got.target  = i_m_tdata[31:0];
                got.seq     = i_m_tdata[47:32];
                if (verdict_q.size() == 0) begin
                    note_failure();
                    if (fails <= 10)
                        $display("unexpected verdict %0d addr %h seq %h, none pending",
                                 got.verdict, got.target, got.seq);
                end else begin
                    want = verdict_q.pop_front();
                    checked++;
                    if (want.verdict != icmp4er_pkg::VERDICT_DROP)
                        hits++;
                    if (got.verdict != want.verdict || got.target != want.target ||
                        got.seq != want.seq) begin
                        note_failure();
                        if (fails <= 10) begin
                            $display("mismatch on verdict %0d: verdict exp %0d got %0d,",
                                     checked, want.verdict, got.verdict);
                            $display("    addr exp %h got %h, seq exp %h got %h",
                                     want.target, got.target, want.seq, got.seq);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                capture_byte(i_s_tdata);
                if (i_s_tlast) begin
                    verdict_q.push_back(judge_packet());
                    clear_capture();
                end
            end
            if (i_cfg_we)
                ident_cfg = i_cfg_wdata;
        end
        o_fail_count <= fails;
        o_pending    <= verdict_q.size();
        o_verdicts   <= checked;
        o_hits       <= hits;
    end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;

    // Description of one packet to build; fields land at their wire offsets.
    typedef struct {
        int          ihl;
        int          len;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [7:0]  kind;
        logic [15:0] ident;
        logic [15:0] seq;
        logic [7:0]  in_proto;
        logic [31:0] in_dest;
        logic [7:0]  in_kind;
        logic [15:0] in_ident;
        logic [15:0] in_seq;
    } t_pkt_spec;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;

    int          fail_count;
    int          pending;
    int          verdicts;
    int          hits;

    logic [7:0]  pkt_bytes[$];
    logic [15:0] cur_ident = '0;
    int          bytes_sent = 0;
    int          packets_sent = 0;
    int          ident_writes = 0;
    int          burst_left = 4;
    bit          no_gaps = 1'b0;
    int          hold_req = 0;

    always #10 clk = ~clk;

    icmp4_echo_reply_classifier uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata)
    );

    echo_verdict_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_verdicts   (verdicts),
        .o_hits       (hits)
    );

    // Receiver: stall on a rotating bit pattern that is periodically redrawn,
    // sometimes all ones so that stretches without stalls occur. A hold-off
    // request from the stimulus drops ready for a long counted stretch.
    initial begin
        logic [31:0] stall_bits;
        int          hold_seen;
        int          hold_left;
        int          tick;
        stall_bits = '1;
        hold_seen  = 0;
        hold_left  = 0;
        tick       = 0;
        forever begin
            @(negedge clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = 400;
            end
            if (tick % 64 == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_bits = '1;
                    1: stall_bits = $urandom;
                    2: stall_bits = $urandom | $urandom;
                    default: stall_bits = $urandom & $urandom;
                endcase
            end
            tick++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= stall_bits[0];
            end
            stall_bits = {stall_bits[0], stall_bits[31:1]};
        end
    end

    // Hard stop: far beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    // Offer one request and hold it until taken; unless no_gaps is set, insert a gap between bursts.
    task automatic send_byte(logic [7:0] b, logic l);
        s_tdata  <= b;
        s_tlast  <= l;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent++;
        @(negedge clk);
        if (!no_gaps) begin
            burst_left--;
            if (burst_left <= 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
                burst_left = $urandom_range(1, 16);
            end
        end
    endtask

    task automatic send_packet();
        foreach (pkt_bytes[i])
            send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
        packets_sent++;
    endtask

    // Drop valid and wait until every verdict is in.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_ident(logic [15:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_ident = v;
        ident_writes++;
    endtask

    // Write a big-endian field into the packet, skipping bytes past its end.
    task automatic put_field(int pos, logic [31:0] v, int nbytes);
        for (int k = 0; k < nbytes; k++)
            if (pos + k < pkt_bytes.size())
                pkt_bytes[pos + k] = v[8 * (nbytes - 1 - k) +: 8];
    endtask

    // ICMP fields go in first, the outer protocol and source last, so with a
    // short IHL the outer fields win where they overlap.
    task automatic build_packet(t_pkt_spec sp);
        int hl;
        hl = sp.ihl * 4;
        pkt_bytes.delete();
        repeat (sp.len) pkt_bytes.push_back(8'($urandom));
        if (sp.len > 0)
            pkt_bytes[0] = {4'h4, 4'(sp.ihl)};
        put_field(hl + icmp4er_pkg::OFF_KIND, 32'(sp.kind), 1);
        put_field(hl + icmp4er_pkg::OFF_IDENT, 32'(sp.ident), 2);
        put_field(hl + icmp4er_pkg::OFF_SEQ, 32'(sp.seq), 2);
        if (sp.kind != icmp4er_pkg::TYPE_ECHO_REPLY) begin
            put_field(hl + icmp4er_pkg::OFF_IN_PROTO, 32'(sp.in_proto), 1);
            put_field(hl + icmp4er_pkg::OFF_IN_DEST, sp.in_dest, 4);
            put_field(hl + icmp4er_pkg::OFF_IN_KIND, 32'(sp.in_kind), 1);
            put_field(hl + icmp4er_pkg::OFF_IN_IDENT, 32'(sp.in_ident), 2);
            put_field(hl + icmp4er_pkg::OFF_IN_SEQ, 32'(sp.in_seq), 2);
        end
        put_field(icmp4er_pkg::OFF_PROTO, 32'(sp.proto), 1);
        put_field(icmp4er_pkg::OFF_SRC, sp.src, 4);
    endtask

    function automatic t_pkt_spec base_spec(logic [7:0] kind, int len);
        t_pkt_spec sp;
        sp.ihl      = 5;
        sp.len      = len;
        sp.proto    = icmp4er_pkg::PROTO_ICMP;
        sp.src      = $urandom;
        sp.kind     = kind;
        sp.ident    = cur_ident;
        sp.seq      = 16'($urandom);
        sp.in_proto = icmp4er_pkg::PROTO_ICMP;
        sp.in_dest  = $urandom;
        sp.in_kind  = icmp4er_pkg::TYPE_ECHO;
        sp.in_ident = cur_ident;
        sp.in_seq   = 16'($urandom);
        return sp;
    endfunction

    // Mostly well-formed replies and errors with random content; some with
    // a wrong identifier, inner header or protocol, some cut short.
    function automatic t_pkt_spec random_spec();
        t_pkt_spec sp;
        int        cat;
        int        hl;
        cat = $urandom_range(0, 99);
        if (cat < 45) begin
            sp = base_spec(icmp4er_pkg::TYPE_ECHO_REPLY, 0);
        end else begin
            sp = base_spec($urandom_range(0, 1) ? icmp4er_pkg::TYPE_UNREACH
                                                : 8'($urandom_range(1, 255)), 0);
        end
        if ($urandom_range(0, 3) == 0)
            sp.ihl = $urandom_range(5, 15);
        else if ($urandom_range(0, 15) == 0)
            sp.ihl = $urandom_range(1, 4);
        hl = sp.ihl * 4;
        if (sp.kind == icmp4er_pkg::TYPE_ECHO_REPLY)
            sp.len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, hl + 8)
                                                 : hl + 8 + $urandom_range(0, 8);
        else
            sp.len = ($urandom_range(0, 6) == 0) ? $urandom_range(hl + 8, hl + 36)
                                                 : hl + 36 + $urandom_range(0, 8);
        if ($urandom_range(0, 9) == 0)
            sp.ident = 16'($urandom);
        if ($urandom_range(0, 9) == 0)
            sp.in_ident = 16'($urandom);
        if ($urandom_range(0, 11) == 0)
            sp.in_proto = 8'($urandom);
        if ($urandom_range(0, 11) == 0)
            sp.in_kind = 8'($urandom);
        if (cat >= 88)
            sp.proto = 8'($urandom);
        return sp;
    endfunction

    initial begin
        t_pkt_spec sp;
        int        start_bytes;
        int        pkt_in_phase;
        int        fill_len;

        // Hold reset low from the start, then release it on a falling edge.
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: identifier all zeros.
        set_ident(16'h0000);
        // minimal echo reply with the extreme sequence and source
        sp = base_spec(icmp4er_pkg::TYPE_ECHO_REPLY, 28);
        sp.seq = 16'hFFFF;
        sp.src = 32'hFFFF_FFFF;
        build_packet(sp);
        send_packet();
        // one byte short of the ICMP header: drop
        sp.len = 27;
        build_packet(sp);
        send_packet();
        // identifier mismatch
        sp = base_spec(icmp4er_pkg::TYPE_ECHO_REPLY, 30);
        sp.ident = 16'h0001;
        build_packet(sp);
        send_packet();
        // not ICMP
        sp = base_spec(icmp4er_pkg::TYPE_ECHO_REPLY, 28);
        sp.proto = 8'h11;
        build_packet(sp);
        send_packet();
        // unreachable carrying our echo request
        sp = base_spec(icmp4er_pkg::TYPE_UNREACH, 56);
        build_packet(sp);
        send_packet();
        // other error type carrying our echo request
        sp = base_spec(8'd11, 60);
        build_packet(sp);
        send_packet();
        // error below the absolute minimum length
        sp = base_spec(8'd11, icmp4er_pkg::ERR_MIN - 1);
        build_packet(sp);
        send_packet();
        // short IHL: error at exactly the minimum, inner id and seq never arrive
        sp = base_spec(icmp4er_pkg::TYPE_UNREACH, icmp4er_pkg::ERR_MIN);
        sp.ihl = 1;
        build_packet(sp);
        send_packet();
        // zero IHL: the ICMP type byte doubles as the first IP byte
        sp = base_spec(icmp4er_pkg::TYPE_ECHO_REPLY, 16);
        sp.ihl = 0;
        build_packet(sp);
        send_packet();
        // largest IHL
        sp = base_spec(icmp4er_pkg::TYPE_ECHO_REPLY, 68);
        sp.ihl = 15;
        build_packet(sp);
        send_packet();
        // inner protocol wrong, then inner type wrong
        sp = base_spec(icmp4er_pkg::TYPE_UNREACH, 56);
        sp.in_proto = 8'h06;
        build_packet(sp);
        send_packet();
        sp = base_spec(8'd4, 56);
        sp.in_kind = icmp4er_pkg::TYPE_ECHO_REPLY;
        build_packet(sp);
        send_packet();
        // single-byte packet, then 40-byte packets of all ones and all zeros
        pkt_bytes.delete();
        pkt_bytes.push_back(8'hFF);
        send_packet();
        pkt_bytes.delete();
        repeat (40) pkt_bytes.push_back(8'hFF);
        send_packet();
        pkt_bytes.delete();
        repeat (40) pkt_bytes.push_back(8'h00);
        send_packet();

        // Directed: identifier all ones.
        set_ident(16'hFFFF);
        sp = base_spec(icmp4er_pkg::TYPE_ECHO_REPLY, 28);
        sp.seq = 16'h0000;
        sp.src = 32'h0000_0000;
        build_packet(sp);
        send_packet();
        sp = base_spec(icmp4er_pkg::TYPE_UNREACH, 56);
        sp.in_dest = 32'hFFFF_FFFF;
        build_packet(sp);
        send_packet();
        sp = base_spec(icmp4er_pkg::TYPE_UNREACH, 56);
        sp.in_ident = 16'hFFFE;
        build_packet(sp);
        send_packet();

        // Random phases, each under its own identifier and sender behavior.
        start_bytes = bytes_sent;
        pkt_in_phase = 0;
        while (bytes_sent - start_bytes < 1100) begin
            if (pkt_in_phase == 12) begin
                pkt_in_phase = 0;
                case ($urandom_range(0, 3))
                    0: set_ident(16'h0000);
                    1: set_ident(16'hFFFF);
                    default: set_ident(16'($urandom));
                endcase
                no_gaps = ($urandom_range(0, 3) == 0);
            end
            if (packets_sent == 24) begin
                // Pressure: stall the receiver long while short packets
                // stream in back to back, so the last byte backs up.
                no_gaps = 1'b1;
                hold_req++;
                repeat (15) begin
                    build_packet(base_spec(icmp4er_pkg::TYPE_ECHO_REPLY, 28));
                    send_packet();
                end
                no_gaps = 1'b0;
            end
            if ($urandom_range(0, 9) == 0) begin
                // pure noise
                fill_len = $urandom_range(1, 40);
                pkt_bytes.delete();
                repeat (fill_len) pkt_bytes.push_back(8'($urandom));
            end else begin
                build_packet(random_spec());
            end
            send_packet();
            pkt_in_phase++;
        end

        drain();
        repeat (10) @(negedge clk);
        $display("sent %0d packets (%0d bytes) under %0d identifier settings",
                 packets_sent, bytes_sent, ident_writes);
        $display("checked %0d verdicts, %0d of them echo matches", verdicts, hits);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
